@@ sv/fgc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgc_pkg: shared types and constants for the FASTA GC-content counter
// Character codes, fraction width and the result record layout.
// ----------------------------------------------------------------------------
package fgc_pkg;

	// Text characters recognized by the parser
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_GT    = 8'd62;
	localparam logic [7:0] CH_A_UC  = 8'd65;
	localparam logic [7:0] CH_C_UC  = 8'd67;
	localparam logic [7:0] CH_G_UC  = 8'd71;
	localparam logic [7:0] CH_T_UC  = 8'd84;
	localparam logic [7:0] CH_A_LC  = 8'd97;
	localparam logic [7:0] CH_C_LC  = 8'd99;
	localparam logic [7:0] CH_G_LC  = 8'd103;
	localparam logic [7:0] CH_T_LC  = 8'd116;

	// Reset value of the minimum base count
	localparam logic [15:0] MIN_BASES_RST = 16'd20;

	// Fraction is unsigned Q1.16
	localparam int FRAC_BITS = 17;
	localparam logic [FRAC_BITS-1:0] FRAC_ONE = 17'h10000;

	// One finished record
	typedef struct packed {
		logic                 too_short;
		logic [FRAC_BITS-1:0] gc_fraction;
		logic [31:0]          all_bases;
		logic [31:0]          gc_bases;
		logic [31:0]          record_number;
	} fgc_result_t;

endpackage

@@ sv/fgc_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgc_parser: FASTA line and record parser
// Tracks line and record state, counts bases per line and commits them at the
// end of each line, and raises a close event with a snapshot of the record.
// ----------------------------------------------------------------------------
module fgc_parser
	import fgc_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic [7:0]             text_byte,
	input  logic                   end_of_stream,
	input  logic [15:0]            min_bases,
	output logic                   close_valid,
	output logic [31:0]            close_num,
	output logic [COUNT_WIDTH-1:0] close_gc,
	output logic [COUNT_WIDTH-1:0] close_tot,
	output logic                   close_short
);

	localparam int CW = COUNT_WIDTH;

	logic [CW-1:0] rec_gc_q, rec_tot_q, ln_gc_q, ln_tot_q;
	logic          ln_sp_q, at_start_q, in_hdr_q, rec_open_q;
	logic [31:0]   emitted_q;

	logic [CW-1:0] rec_gc_d, rec_tot_d, ln_gc_d, ln_tot_d;
	logic          ln_sp_d, at_start_d, in_hdr_d, rec_open_d;
	logic          handled, end_req, close_any;
	logic          is_at, is_cg;

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CW] ? '1 : s[CW-1:0];
	endfunction

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] a);
		return (a == '1) ? a : a + CW'(1);
	endfunction

	// Classify the byte
	assign is_at = (text_byte == CH_A_UC) || (text_byte == CH_A_LC) ||
	               (text_byte == CH_T_UC) || (text_byte == CH_T_LC);
	assign is_cg = (text_byte == CH_C_UC) || (text_byte == CH_C_LC) ||
	               (text_byte == CH_G_UC) || (text_byte == CH_G_LC);

	// Next parse state for one byte
	always_comb begin
		rec_gc_d   = rec_gc_q;
		rec_tot_d  = rec_tot_q;
		ln_gc_d    = ln_gc_q;
		ln_tot_d   = ln_tot_q;
		ln_sp_d    = ln_sp_q;
		at_start_d = at_start_q;
		in_hdr_d   = in_hdr_q;
		rec_open_d = rec_open_q;
		handled    = 1'b0;
		end_req    = 1'b0;
		close_any  = 1'b0;
		close_gc   = rec_gc_q;
		close_tot  = rec_tot_q;

		// Header or empty line at line start closes the open record
		if (at_start_q && (text_byte == CH_GT)) begin
			close_any  = rec_open_q;
			rec_open_d = 1'b0;
			rec_gc_d   = '0;
			rec_tot_d  = '0;
			in_hdr_d   = 1'b1;
			at_start_d = 1'b0;
			handled    = 1'b1;
		end else if (at_start_q && (text_byte == CH_LF)) begin
			close_any  = rec_open_q;
			rec_open_d = 1'b0;
			rec_gc_d   = '0;
			rec_tot_d  = '0;
			in_hdr_d   = 1'b0;
			ln_gc_d    = '0;
			ln_tot_d   = '0;
			ln_sp_d    = 1'b0;
			handled    = 1'b1;
		end

		// Ordinary byte: newline ends the line, others are counted
		if (!handled) begin
			if (text_byte == CH_LF) begin
				end_req = 1'b1;
			end else begin
				at_start_d = 1'b0;
				if (in_hdr_q) begin
					rec_open_d = 1'b1;
				end else if (rec_open_q) begin
					if (text_byte == CH_SPACE) begin
						ln_sp_d = 1'b1;
					end else if (is_at) begin
						ln_tot_d = sat_inc(ln_tot_q);
					end else if (is_cg) begin
						ln_tot_d = sat_inc(ln_tot_q);
						ln_gc_d  = sat_inc(ln_gc_q);
					end
				end
			end
		end

		// Final byte ends a line still in progress
		if (end_of_stream && (!at_start_d || in_hdr_d)) begin
			end_req = 1'b1;
		end

		// Commit or drop the line
		if (end_req) begin
			if (in_hdr_d) begin
				in_hdr_d = 1'b0;
			end else if (rec_open_d) begin
				if (ln_sp_d) begin
					rec_open_d = 1'b0;
					rec_gc_d   = '0;
					rec_tot_d  = '0;
				end else begin
					rec_gc_d  = sat_add(rec_gc_d, ln_gc_d);
					rec_tot_d = sat_add(rec_tot_d, ln_tot_d);
				end
			end
			ln_gc_d    = '0;
			ln_tot_d   = '0;
			ln_sp_d    = 1'b0;
			at_start_d = 1'b1;
		end

		// Final byte closes the record and returns to the start state
		if (end_of_stream) begin
			if (!close_any && rec_open_d) begin
				close_any = 1'b1;
				close_gc  = rec_gc_d;
				close_tot = rec_tot_d;
			end
			rec_open_d = 1'b0;
			rec_gc_d   = '0;
			rec_tot_d  = '0;
			ln_gc_d    = '0;
			ln_tot_d   = '0;
			ln_sp_d    = 1'b0;
			at_start_d = 1'b1;
			in_hdr_d   = 1'b0;
		end
	end

	assign close_valid = accept && close_any;
	assign close_num   = emitted_q;
	assign close_short = (64'(close_tot) < 64'(min_bases)) || (close_tot == '0);

	// Advance parse state on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_gc_q   <= '0;
			rec_tot_q  <= '0;
			ln_gc_q    <= '0;
			ln_tot_q   <= '0;
			ln_sp_q    <= 1'b0;
			at_start_q <= 1'b1;
			in_hdr_q   <= 1'b0;
			rec_open_q <= 1'b0;
			emitted_q  <= '0;
		end else if (accept) begin
			rec_gc_q   <= rec_gc_d;
			rec_tot_q  <= rec_tot_d;
			ln_gc_q    <= ln_gc_d;
			ln_tot_q   <= ln_tot_d;
			ln_sp_q    <= ln_sp_d;
			at_start_q <= at_start_d;
			in_hdr_q   <= in_hdr_d;
			rec_open_q <= rec_open_d;
			if (close_any) begin
				emitted_q <= emitted_q + 32'd1;
			end
		end
	end

endmodule

@@ sv/fgc_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fgc_divider: iterative GC fraction unit
// Restoring divider, one quotient bit per cycle through one shared
// compare-and-subtract, under a three-state sequencer that holds the result.
// ----------------------------------------------------------------------------
module fgc_divider
	import fgc_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [31:0]            start_num,
	input  logic [COUNT_WIDTH-1:0] start_gc,
	input  logic [COUNT_WIDTH-1:0] start_tot,
	input  logic                   start_short,
	output logic                   idle,
	output logic                   res_valid,
	input  logic                   res_take,
	output fgc_result_t            res
);

	localparam int CW = COUNT_WIDTH;
	localparam int CNT_W = $clog2(FRAC_BITS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} div_state_t;

	div_state_t     state_q;
	logic [CW:0]    rem_q;
	logic [CW-1:0]  dvs_q;
	logic [CNT_W-1:0] cnt_q;
	fgc_result_t    res_q;

	logic [CW:0]    diff;
	logic           ge;
	logic [CW-1:0]  rem_next;
	logic [63:0]    gc_ext, tot_ext;

	// Shared compare and subtract
	assign ge       = rem_q >= {1'b0, dvs_q};
	assign diff     = rem_q - {1'b0, dvs_q};
	assign rem_next = ge ? diff[CW-1:0] : rem_q[CW-1:0];

	// Clamp counts to the 32-bit result fields
	assign gc_ext  = 64'(start_gc);
	assign tot_ext = 64'(start_tot);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= start_short ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath: load the snapshot, then shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if ((state_q == ST_IDLE) && start) begin
			rem_q                 <= {1'b0, start_gc};
			dvs_q                 <= start_tot;
			cnt_q                 <= CNT_W'(FRAC_BITS - 1);
			res_q.record_number   <= start_num;
			res_q.gc_bases        <= (gc_ext > 64'h0000_0000_FFFF_FFFF) ? '1 : gc_ext[31:0];
			res_q.all_bases       <= (tot_ext > 64'h0000_0000_FFFF_FFFF) ? '1 : tot_ext[31:0];
			res_q.gc_fraction     <= '0;
			res_q.too_short       <= start_short;
		end else if (state_q == ST_DIV) begin
			rem_q             <= {rem_next, 1'b0};
			cnt_q             <= cnt_q - CNT_W'(1);
			res_q.gc_fraction <= {res_q.gc_fraction[FRAC_BITS-2:0], ge};
		end
	end

	assign idle      = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_IDLE)
		else $error("divider started while busy");
	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && res_q.too_short |-> res_q.gc_fraction == '0)
		else $error("short record with nonzero fraction");
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> res_q.gc_fraction <= FRAC_ONE)
		else $error("fraction above one");
	a_div_long: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> !res_q.too_short)
		else $error("dividing a short record");
	a_take_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |-> state_q == ST_DONE)
		else $error("result taken when none is ready");
`endif

endmodule

@@ sv/fasta_gc_content.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fasta_gc_content: FASTA GC-content counter
// Parses FASTA text one byte per word and emits per-record GC statistics.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the divider is idle. A byte that closes
// a record holds s_tready low while the fraction is formed by a restoring
// divider, one bit per cycle for all 17 quotient bits, and handed into the
// output register; a short record skips the division. The divider hands
// its result on only when the output register is free, so a stalled consumer
// stalls the input after that one pending record. min_bases may be written
// whenever the block is idle; cfg_ready is always high.
// ----------------------------------------------------------------------------
module fasta_gc_content
	import fgc_pkg::*;
#(
	parameter int COUNT_WIDTH = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	// Text input
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] text_byte
	input  logic         s_tlast,   // end_of_stream
	// Record results
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [119:0] m_tdata,   // [31:0] record_number, [63:32] gc_bases,
	                                // [95:64] all_bases, [112:96] gc_fraction,
	                                // [119:113] zero
	output logic         m_tuser,   // too_short
	// Minimum base count register
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	logic                   accept;
	logic [15:0]            min_bases_q;
	logic                   close_valid, close_short;
	logic [31:0]            close_num;
	logic [COUNT_WIDTH-1:0] close_gc, close_tot;
	logic                   div_idle, res_valid, res_take;
	fgc_result_t            res;
	logic                   out_valid_q;
	fgc_result_t            out_q;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = div_idle;
	assign cfg_ready = 1'b1;

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bases_q <= MIN_BASES_RST;
		end else if (cfg_valid) begin
			min_bases_q <= cfg_data;
		end
	end

	fgc_parser #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.text_byte    (s_tdata),
		.end_of_stream(s_tlast),
		.min_bases    (min_bases_q),
		.close_valid  (close_valid),
		.close_num    (close_num),
		.close_gc     (close_gc),
		.close_tot    (close_tot),
		.close_short  (close_short)
	);

	fgc_divider #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (close_valid),
		.start_num  (close_num),
		.start_gc   (close_gc),
		.start_tot  (close_tot),
		.start_short(close_short),
		.idle       (div_idle),
		.res_valid  (res_valid),
		.res_take   (res_take),
		.res        (res)
	);

	// Output register: load when empty or being drained
	assign res_take = res_valid && (!out_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_q.gc_fraction, out_q.all_bases, out_q.gc_bases,
	                   out_q.record_number};
	assign m_tuser  = out_q.too_short;

endmodule
